FILE: src/nta_pkg.sv
// ----------------------------------------------------------------------------
// nta_pkg
// Shared constants, codes and helpers of the neighbour table with aging.
// ----------------------------------------------------------------------------
`default_nettype none

package nta_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

  localparam logic [7:0] TIMEOUT_RESET = 8'd15;
  localparam logic [4:0] COUNT_MAX     = 5'd31;

  // request codes
  localparam logic [1:0] REQ_HELLO = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // clamp an internal count onto the 5-bit result fields
  function automatic logic [4:0] sat_count(input logic [CNT_W-1:0] n);
    logic [4:0] r;
    if (32'(n) > 32'(COUNT_MAX)) begin
      r = COUNT_MAX;
    end else begin
      r = 5'(n);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/nta_if.sv
// ----------------------------------------------------------------------------
// nta channel interfaces
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface nta_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] router_id;
  logic [31:0] source_ip;
  logic [31:0] net_mask;
  logic [3:0]  slot_index;

  modport source (output valid, req_type, router_id, source_ip, net_mask, slot_index,
                  input ready);
  modport sink   (input valid, req_type, router_id, source_ip, net_mask, slot_index,
                  output ready);
endinterface

interface nta_res_if;
  logic        valid;
  logic        ready;
  logic        table_changed;
  logic        new_neighbour;
  logic        table_full_drop;
  logic [4:0]  expired_count;
  logic [4:0]  neighbour_count;
  logic        read_valid;
  logic [31:0] read_router_id;
  logic [31:0] read_network;
  logic [31:0] read_mask;

  modport source (output valid, table_changed, new_neighbour, table_full_drop,
                  expired_count, neighbour_count, read_valid, read_router_id,
                  read_network, read_mask,
                  input ready);
  modport sink   (input valid, table_changed, new_neighbour, table_full_drop,
                  expired_count, neighbour_count, read_valid, read_router_id,
                  read_network, read_mask,
                  output ready);
endinterface

`default_nettype wire

FILE: src/neighbour_table_with_aging_top.sv
// ----------------------------------------------------------------------------
// neighbour_table_with_aging_top
// Neighbour table of a link-state router with hello refresh and tick aging.
// ----------------------------------------------------------------------------
// Usage:
//   in_item  : request channel. req_type 0 = hello (router_id, source_ip,
//              net_mask), 1 = one-second tick, 2 = read slot_index.
//   out_res  : one result per request, valid/ready.
//   cfg_we / cfg_wdata : timeout in ticks, write only while idle.
// Timing:
//   hello and tick run one pass over all slots through a single table read
//   port, one slot per cycle; after the scan a hello passes ST_UPDATE and
//   then ST_DONE, a tick goes straight to ST_DONE, a read ST_READ, ST_DONE.
//   one request is in flight at a time; in_item.ready is high only when idle.
// Reset: all slots empty, timeout 15, no result pending. Table payload is
//   not cleared; only the valid bits are.
// Stall: a finished result waits in the output register; the block goes idle
//   and may take the next request, but holds that one's result until the
//   pending result transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module neighbour_table_with_aging_top
  import nta_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  nta_req_if.sink    in_item,
  nta_res_if.source  out_res,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_UPDATE = 5'b00100,
    ST_READ   = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  // table storage
  logic [31:0] id_mem   [TABLE_ENTRIES];
  logic [31:0] addr_mem [TABLE_ENTRIES];
  logic [31:0] mask_mem [TABLE_ENTRIES];
  logic [7:0]  age_mem  [TABLE_ENTRIES];

  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  state_t                   state_r, state_nxt;
  logic [7:0]               timeout_r;

  // latched request
  logic [1:0]  req_r;
  logic [31:0] rid_r, src_r, msk_r;
  logic [3:0]  slot_r;

  // scan control
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] pend_idx_r, pend_idx_nxt;
  logic             found_r, found_nxt, free_r, free_nxt;
  logic [IDX_W-1:0] hit_r, hit_nxt, free_idx_r, free_idx_nxt;
  logic [CNT_W-1:0] exp_r, exp_nxt, nb_r, nb_nxt;
  logic             ins_r, ins_nxt, drop_r, drop_nxt;

  // read port
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [31:0]      id_q, addr_q, mask_q;
  logic [7:0]       age_q;

  // write port
  logic             wr_id_en, wr_data_en, wr_age_en;
  logic [IDX_W-1:0] wr_addr;
  logic [7:0]       wr_age;

  // result register
  logic        out_valid_r;
  logic        out_changed_r, out_new_r, out_drop_r, out_rvalid_r;
  logic [4:0]  out_exp_r, out_nb_r;
  logic [31:0] out_rid_r, out_net_r, out_mask_r;
  logic        out_load;

  logic        in_fire, scan_last, slot_ok;
  logic [8:0]  age_inc;
  logic        age_expire;

  assign in_fire   = in_item.valid && in_item.ready;
  assign scan_last = (cnt_r == CNT_W'(TABLE_ENTRIES));
  assign slot_ok   = (32'(slot_r) < 32'(TABLE_ENTRIES));
  assign age_inc   = {1'b0, age_q} + 9'd1;
  assign age_expire = (age_inc >= {1'b0, timeout_r});
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_res.ready);

  assign rd_en   = ((state_r == ST_SCAN) && !scan_last) || (state_r == ST_READ);
  assign rd_addr = (state_r == ST_READ) ? IDX_W'(slot_r) : cnt_r[IDX_W-1:0];

  always_comb begin
    state_nxt    = state_r;
    valid_nxt    = valid_r;
    cnt_nxt      = cnt_r;
    pend_nxt     = 1'b0;
    pend_idx_nxt = cnt_r[IDX_W-1:0];
    found_nxt    = found_r;
    free_nxt     = free_r;
    hit_nxt      = hit_r;
    free_idx_nxt = free_idx_r;
    exp_nxt      = exp_r;
    nb_nxt       = nb_r;
    ins_nxt      = ins_r;
    drop_nxt     = drop_r;
    wr_id_en     = 1'b0;
    wr_data_en   = 1'b0;
    wr_age_en    = 1'b0;
    wr_addr      = pend_idx_r;
    wr_age       = 8'd0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cnt_nxt   = '0;
          found_nxt = 1'b0;
          free_nxt  = 1'b0;
          exp_nxt   = '0;
          ins_nxt   = 1'b0;
          drop_nxt  = 1'b0;
          case (in_item.req_type)
            REQ_HELLO, REQ_TICK: state_nxt = ST_SCAN;
            REQ_READ:            state_nxt = ST_READ;
            default:             state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (!scan_last) begin
          cnt_nxt  = cnt_r + CNT_W'(1);
          pend_nxt = 1'b1;
        end
        // evaluate the slot whose data came back this cycle
        if (pend_r) begin
          if (req_r == REQ_HELLO) begin
            if (valid_r[pend_idx_r]) begin
              if (!found_r && id_q == rid_r) begin
                found_nxt = 1'b1;
                hit_nxt   = pend_idx_r;
              end
            end else if (!free_r) begin
              free_nxt     = 1'b1;
              free_idx_nxt = pend_idx_r;
            end
          end else if (valid_r[pend_idx_r]) begin
            if (age_expire) begin
              valid_nxt[pend_idx_r] = 1'b0;
              exp_nxt = exp_r + CNT_W'(1);
              nb_nxt  = nb_r - CNT_W'(1);
            end else begin
              wr_age_en = 1'b1;
              wr_age    = age_inc[7:0];
            end
          end
        end
        if (scan_last) begin
          state_nxt = (req_r == REQ_HELLO) ? ST_UPDATE : ST_DONE;
        end
      end
      ST_UPDATE: begin
        if (found_r) begin
          wr_addr    = hit_r;
          wr_data_en = 1'b1;
          wr_age_en  = 1'b1;
        end else if (free_r) begin
          wr_addr    = free_idx_r;
          wr_id_en   = 1'b1;
          wr_data_en = 1'b1;
          wr_age_en  = 1'b1;
          valid_nxt[free_idx_r] = 1'b1;
          nb_nxt  = nb_r + CNT_W'(1);
          ins_nxt = 1'b1;
        end else begin
          drop_nxt = 1'b1;
        end
        state_nxt = ST_DONE;
      end
      ST_READ: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      valid_r   <= '0;
      nb_r      <= '0;
      timeout_r <= TIMEOUT_RESET;
      pend_r    <= 1'b0;
      cnt_r     <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      nb_r    <= nb_nxt;
      pend_r  <= pend_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_we) begin
        timeout_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    found_r    <= found_nxt;
    free_r     <= free_nxt;
    hit_r      <= hit_nxt;
    free_idx_r <= free_idx_nxt;
    exp_r      <= exp_nxt;
    ins_r      <= ins_nxt;
    drop_r     <= drop_nxt;
    if (in_fire) begin
      req_r  <= in_item.req_type;
      rid_r  <= in_item.router_id;
      src_r  <= in_item.source_ip;
      msk_r  <= in_item.net_mask;
      slot_r <= in_item.slot_index;
    end
  end

  // table memories: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_id_en) begin
      id_mem[wr_addr] <= rid_r;
    end
    if (wr_data_en) begin
      addr_mem[wr_addr] <= src_r;
      mask_mem[wr_addr] <= msk_r;
    end
    if (wr_age_en) begin
      age_mem[wr_addr] <= wr_age;
    end
    if (rd_en) begin
      id_q   <= id_mem[rd_addr];
      addr_q <= addr_mem[rd_addr];
      mask_q <= mask_mem[rd_addr];
      age_q  <= age_mem[rd_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_changed_r <= 1'b0;
      out_new_r     <= 1'b0;
      out_drop_r    <= 1'b0;
      out_exp_r     <= 5'd0;
      out_rvalid_r  <= 1'b0;
      out_rid_r     <= 32'd0;
      out_net_r     <= 32'd0;
      out_mask_r    <= 32'd0;
      out_nb_r      <= sat_count(nb_r);
      case (req_r)
        REQ_HELLO: begin
          out_changed_r <= ins_r;
          out_new_r     <= ins_r;
          out_drop_r    <= drop_r;
        end
        REQ_TICK: begin
          out_changed_r <= (exp_r != '0);
          out_exp_r     <= sat_count(exp_r);
        end
        REQ_READ: begin
          if (slot_ok && valid_r[IDX_W'(slot_r)]) begin
            out_rvalid_r <= 1'b1;
            out_rid_r    <= id_q;
            out_net_r    <= addr_q & mask_q;
            out_mask_r   <= mask_q;
          end
        end
        default: begin
          out_changed_r <= 1'b0;
        end
      endcase
    end
  end

  assign in_item.ready           = (state_r == ST_IDLE);
  assign out_res.valid           = out_valid_r;
  assign out_res.table_changed   = out_changed_r;
  assign out_res.new_neighbour   = out_new_r;
  assign out_res.table_full_drop = out_drop_r;
  assign out_res.expired_count   = out_exp_r;
  assign out_res.neighbour_count = out_nb_r;
  assign out_res.read_valid      = out_rvalid_r;
  assign out_res.read_router_id  = out_rid_r;
  assign out_res.read_network    = out_net_r;
  assign out_res.read_mask       = out_mask_r;

  // running count matches the valid bits between requests
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (32'(nb_r) == $countones(valid_r)))
    else $error("neighbour count out of step with valid bits");

  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != ST_IDLE))
    else $error("request transfer did not start work");

  a_changed_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_changed_r) |-> (out_new_r || (out_exp_r != 5'd0)))
    else $error("table change reported without insert or expiry");

  a_drop_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_drop_r) |-> (!out_new_r && !out_changed_r))
    else $error("drop reported together with insert");

endmodule

`default_nettype wire

FILE: test/neighbour_table_with_aging_top_test.sv
// ----------------------------------------------------------------------------
// neighbour_table_with_aging_top_test
// Drives hello, tick and read requests into the neighbour table under random
// handshake gaps and long result stalls, across several timeout settings.
// A behavioral copy of the table predicts every result and each transfer on
// the result channel is checked field by field against it.
// ----------------------------------------------------------------------------
`default_nettype none

module neighbour_table_with_aging_top_test;
  import nta_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int         ID_POOL    = 24;
  localparam int         LONG_HOLD  = 300;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] id;
    logic [31:0] src;
    logic [31:0] mask;
    logic [3:0]  slot;
  } nbr_req_t;

  typedef struct packed {
    logic        table_changed;
    logic        new_neighbour;
    logic        table_full_drop;
    logic [4:0]  expired_count;
    logic [4:0]  neighbour_count;
    logic        read_valid;
    logic [31:0] read_router_id;
    logic [31:0] read_network;
    logic [31:0] read_mask;
  } reply_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  nta_req_if in_item ();
  nta_res_if out_res ();

  neighbour_table_with_aging_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // predicted table contents
  bit          nb_valid [TABLE_ENTRIES] = '{default: 1'b0};
  logic [31:0] nb_id    [TABLE_ENTRIES];
  logic [31:0] nb_addr  [TABLE_ENTRIES];
  logic [31:0] nb_mask  [TABLE_ENTRIES];
  logic [7:0]  nb_age   [TABLE_ENTRIES];
  logic [7:0]  timeout_cfg = TIMEOUT_RESET;

  reply_t      replies_due [$];
  logic [31:0] id_pool [ID_POOL];
  int          errors  = 0;
  bit          no_idle = 1'b0;
  logic        holding;
  event        hold_ev;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic reply_t table_reply(nbr_req_t r);
    reply_t y;
    int     hit;
    int     free_slot;
    int     aged;
    int     n;
    y         = '0;
    hit       = -1;
    free_slot = -1;
    case (r.kind)
      REQ_HELLO: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (nb_valid[i]) begin
            if (hit < 0 && nb_id[i] == r.id) hit = i;
          end else if (free_slot < 0) begin
            free_slot = i;
          end
        end
        if (hit >= 0) begin
          // refresh of a known neighbour is not a table change
          nb_addr[hit] = r.src;
          nb_mask[hit] = r.mask;
          nb_age[hit]  = '0;
        end else if (free_slot >= 0) begin
          nb_valid[free_slot] = 1'b1;
          nb_id[free_slot]    = r.id;
          nb_addr[free_slot]  = r.src;
          nb_mask[free_slot]  = r.mask;
          nb_age[free_slot]   = '0;
          y.table_changed     = 1'b1;
          y.new_neighbour     = 1'b1;
        end else begin
          y.table_full_drop = 1'b1;
        end
      end
      REQ_TICK: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (nb_valid[i]) begin
            aged = int'(nb_age[i]) + 1;
            if (aged >= int'(timeout_cfg)) begin
              nb_valid[i] = 1'b0;
              nb_age[i]   = '0;
              y.expired_count++;
            end else begin
              nb_age[i] = 8'(aged);
            end
          end
        end
        y.table_changed = (y.expired_count != 0);
      end
      REQ_READ: begin
        if (int'(r.slot) < TABLE_ENTRIES && nb_valid[r.slot]) begin
          y.read_valid     = 1'b1;
          y.read_router_id = nb_id[r.slot];
          y.read_network   = nb_addr[r.slot] & nb_mask[r.slot];
          y.read_mask      = nb_mask[r.slot];
        end
      end
      default: ;
    endcase
    n = 0;
    for (int i = 0; i < TABLE_ENTRIES; i++) n += nb_valid[i];
    y.neighbour_count = (n > int'(COUNT_MAX)) ? COUNT_MAX : 5'(n);
    return y;
  endfunction

  function automatic void field_check(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  task automatic check_reply(reply_t got);
    reply_t want;
    if (replies_due.size() == 0) begin
      $error("result transfer with no request outstanding");
      errors++;
    end else begin
      want = replies_due.pop_front();
      field_check("table_changed",   32'(want.table_changed),   32'(got.table_changed));
      field_check("new_neighbour",   32'(want.new_neighbour),   32'(got.new_neighbour));
      field_check("table_full_drop", 32'(want.table_full_drop), 32'(got.table_full_drop));
      field_check("expired_count",   32'(want.expired_count),   32'(got.expired_count));
      field_check("neighbour_count", 32'(want.neighbour_count), 32'(got.neighbour_count));
      field_check("read_valid",      32'(want.read_valid),      32'(got.read_valid));
      field_check("read_router_id",  want.read_router_id,       got.read_router_id);
      field_check("read_network",    want.read_network,         got.read_network);
      field_check("read_mask",       want.read_mask,            got.read_mask);
    end
  endtask

  // result side: random stall after every transfer (none while no_idle), plus the long hold
  initial begin : reply_sink
    int unsigned stall_left;
    reply_t      got;
    stall_left = 0;
    out_res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_res.valid && out_res.ready) begin
        got.table_changed   = out_res.table_changed;
        got.new_neighbour   = out_res.new_neighbour;
        got.table_full_drop = out_res.table_full_drop;
        got.expired_count   = out_res.expired_count;
        got.neighbour_count = out_res.neighbour_count;
        got.read_valid      = out_res.read_valid;
        got.read_router_id  = out_res.read_router_id;
        got.read_network    = out_res.read_network;
        got.read_mask       = out_res.read_mask;
        check_reply(got);
        stall_left = no_idle ? 0 : $urandom_range(0, 9);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_res.ready <= rst_n && (stall_left == 0) && !holding;
    end
  end

  initial begin : long_hold
    holding <= 1'b0;
    forever begin
      @(hold_ev);
      holding <= 1'b1;
      repeat (LONG_HOLD) @(posedge clk);
      holding <= 1'b0;
    end
  end

  initial begin
    #5_000_000;
    $display("neighbour_table_with_aging_top regression: fail");
    $finish;
  end

  function automatic nbr_req_t make_req(logic [1:0] kind, logic [31:0] id, logic [31:0] src,
                                        logic [31:0] mask, logic [3:0] slot);
    nbr_req_t r;
    r.kind = kind;
    r.id   = id;
    r.src  = src;
    r.mask = mask;
    r.slot = slot;
    return r;
  endfunction

  // ids mostly from a small pool so that refreshes, expiry and full table all occur
  function automatic nbr_req_t rand_request(int unsigned hello_pct, int unsigned tick_pct);
    nbr_req_t    r;
    int unsigned pick;
    pick   = $urandom_range(0, 99);
    r.kind = (pick < hello_pct) ? REQ_HELLO :
             (pick < hello_pct + tick_pct) ? REQ_TICK : REQ_READ;
    r.id   = ($urandom_range(0, 9) == 0) ? $urandom : id_pool[$urandom_range(0, ID_POOL - 1)];
    r.src  = $urandom;
    r.mask = $urandom_range(0, 1) ? $urandom : ~(32'hFFFF_FFFF >> $urandom_range(0, 32));
    r.slot = 4'($urandom_range(0, 15));
    return r;
  endfunction

  task automatic send_item(nbr_req_t r);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_item.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item.valid      <= 1'b1;
    in_item.req_type   <= r.kind;
    in_item.router_id  <= r.id;
    in_item.source_ip  <= r.src;
    in_item.net_mask   <= r.mask;
    in_item.slot_index <= r.slot;
    do @(posedge clk); while (!in_item.ready);
    replies_due = {replies_due, table_reply(r)};
  endtask

  task automatic wait_table_idle();
    if (in_item.valid) in_item.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_timeout(logic [7:0] ticks);
    wait_table_idle();
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= ticks;
    @(posedge clk);
    cfg_we      <= 1'b0;
    timeout_cfg  = ticks;
  endtask

  task automatic test_directed();
    send_item(make_req(REQ_HELLO, 32'h0, 32'hFFFF_FFFF, 32'h0, 4'd0));
    send_item(make_req(REQ_HELLO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15));
    send_item(make_req(REQ_READ, 32'h0, 32'h0, 32'h0, 4'd0));
    send_item(make_req(REQ_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd1));
    send_item(make_req(REQ_HELLO, 32'h0, 32'h0A00_0001, 32'hFFFF_FF00, 4'd0));
    send_item(make_req(REQ_READ, 32'h0, 32'h0, 32'h0, 4'd0));
    send_item(make_req(REQ_READ, 32'h0, 32'h0, 32'h0, 4'd15));
    send_item(make_req(REQ_UNUSED, $urandom, $urandom, $urandom, 4'($urandom_range(0, 15))));
    send_item(make_req(REQ_TICK, 32'h0, 32'h0, 32'h0, 4'd0));
    send_item(make_req(REQ_HELLO, 32'h1234_5678, 32'hC0A8_0101, 32'hFFFF_0000, 4'd0));
    send_item(make_req(REQ_READ, 32'h0, 32'h0, 32'h0, 4'd2));
    wait_table_idle();
  endtask

  task automatic test_fill_and_drop();
    nbr_req_t    r;
    logic [31:0] fresh_ids [TABLE_ENTRIES];
    // more new ids than free slots: the last ones are dropped
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      r            = rand_request(100, 0);
      r.id         = $urandom;
      fresh_ids[i] = r.id;
      send_item(r);
    end
    // refresh of known ids while full
    for (int i = 0; i < 3; i++) begin
      r    = rand_request(100, 0);
      r.id = fresh_ids[i];
      send_item(r);
    end
    for (int s = 0; s < 16; s++) begin
      r      = rand_request(0, 0);
      r.slot = 4'(s);
      send_item(r);
    end
    // enough ticks at the reset timeout to age out every entry
    repeat (int'(TIMEOUT_RESET)) send_item(rand_request(0, 100));
    wait_table_idle();
  endtask

  task automatic test_timeout_min();
    set_timeout(8'd1);
    repeat (40) send_item(rand_request(55, 30));
    wait_table_idle();
  endtask

  task automatic test_timeout_max();
    set_timeout(8'd255);
    repeat (8) send_item(rand_request(100, 0));
    repeat (330) send_item(rand_request(2, 88));
    wait_table_idle();
  endtask

  // old entries expire on the first tick after the timeout is lowered
  task automatic test_timeout_lower();
    set_timeout(8'd40);
    repeat (60) send_item(rand_request(45, 35));
    set_timeout(8'd3);
    repeat (30) send_item(rand_request(40, 30));
    wait_table_idle();
  endtask

  task automatic test_backpressure();
    no_idle = 1'b1;
    -> hold_ev;
    repeat (30) send_item(rand_request(50, 20));
    wait_table_idle();
    no_idle = 1'b0;
  endtask

  task automatic test_random();
    int unsigned hello_pct;
    int unsigned tick_pct;
    for (int ph = 0; ph < 10; ph++) begin
      set_timeout(8'($urandom_range(2, 24)));
      no_idle   = (ph % 3 == 2);
      hello_pct = $urandom_range(30, 60);
      tick_pct  = $urandom_range(5, 35);
      repeat (100) send_item(rand_request(hello_pct, tick_pct));
    end
    no_idle = 1'b0;
    wait_table_idle();
  endtask

  initial begin
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= 8'd0;
    in_item.valid      <= 1'b0;
    in_item.req_type   <= REQ_HELLO;
    in_item.router_id  <= '0;
    in_item.source_ip  <= '0;
    in_item.net_mask   <= '0;
    in_item.slot_index <= '0;
    id_pool[0] = 32'h0;
    id_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < ID_POOL; i++) id_pool[i] = $urandom;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_fill_and_drop();
    test_timeout_min();
    test_timeout_max();
    test_timeout_lower();
    test_backpressure();
    test_random();

    wait_table_idle();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("neighbour_table_with_aging_top regression: pass");
    end else begin
      $display("neighbour_table_with_aging_top regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
